// ===== hdl/bpa_pkg.sv =====
// bitmap page allocator: shared constants, codes and types
// no dependencies; used by the interfaces and every module in hdl/
package bpa_pkg;

   localparam int NUM_PAGES  = 64;
   // page size must be a power of two
   localparam int PAGE_BYTES = 4096;
   localparam int POOL_BASE  = 1048576;

   localparam int MAP_BITS   = 64;
   localparam int ADDR_W     = 32;
   localparam int PIDX_W     = $clog2(MAP_BITS);
   localparam int CNT_W      = $clog2(MAP_BITS + 1);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PNUM_W     = ADDR_W - PAGE_SHIFT;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_MISALIGNED = 2'd2,
      ST_RANGE      = 2'd3
   } status_type;

   // result of the free address check
   typedef struct packed {
      status_type          status;
      logic [PIDX_W-1:0]   idx;
   } chk_result_type;

   // state of the shared scan unit
   typedef struct packed {
      logic                busy;
      logic                found;
      logic [PIDX_W-1:0]   idx;
      logic [CNT_W-1:0]    ones;
      logic [ADDR_W-1:0]   addr;
   } scan_status_type;

endpackage

// ===== hdl/bpa_if.sv =====
// valid/ready channel interfaces for requests and responses
// depends on bpa_pkg
interface bpa_req_if;
   logic                       valid;
   logic                       ready;
   bpa_pkg::opcode_type        opcode;
   logic [bpa_pkg::ADDR_W-1:0] free_addr;

   modport source (output valid, opcode, free_addr, input ready);
   modport sink   (input valid, opcode, free_addr, output ready);
endinterface

interface bpa_rsp_if;
   logic                        valid;
   logic                        ready;
   bpa_pkg::status_type         status;
   logic [bpa_pkg::ADDR_W-1:0]  alloc_addr;
   logic [bpa_pkg::MAP_BITS-1:0] occupancy_map;
   logic [bpa_pkg::CNT_W-1:0]   free_pages;
   logic [bpa_pkg::CNT_W-1:0]   used_pages;

   modport source (output valid, status, alloc_addr, occupancy_map, free_pages, used_pages,
                   input ready);
   modport sink   (input valid, status, alloc_addr, occupancy_map, free_pages, used_pages,
                   output ready);
endinterface

// ===== hdl/bpa_addr_chk.sv =====
// free address check: range, alignment and page index
// depends on bpa_pkg
module bpa_addr_chk (
   input  logic [bpa_pkg::ADDR_W-1:0] free_addr,
   output bpa_pkg::chk_result_type    result
);
   import bpa_pkg::*;

   logic [ADDR_W-1:0] offset;
   logic [PNUM_W-1:0] page_num;

   assign offset   = free_addr - ADDR_W'(POOL_BASE);
   assign page_num = offset[ADDR_W-1:PAGE_SHIFT];

   always_comb begin
      result.idx = page_num[PIDX_W-1:0];
      if (free_addr < ADDR_W'(POOL_BASE)) begin
         result.status = ST_RANGE;
      end else if (offset[PAGE_SHIFT-1:0] != '0) begin
         result.status = ST_MISALIGNED;
      end else if (page_num >= PNUM_W'(NUM_PAGES)) begin
         result.status = ST_RANGE;
      end else begin
         result.status = ST_OK;
      end
   end

endmodule

// ===== hdl/bpa_scan_unit.sv =====
// shared bit-serial scan: one map bit a cycle, counts used pages,
// finds the first free page and its address; depends on bpa_pkg
module bpa_scan_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bpa_pkg::MAP_BITS-1:0]  map,
   output bpa_pkg::scan_status_type      scan
);
   import bpa_pkg::*;

   logic                busy_ff,  busy_in;
   logic                found_ff, found_in;
   logic [PIDX_W-1:0]   cnt_ff,   cnt_in;
   logic [PIDX_W-1:0]   idx_ff,   idx_in;
   logic [CNT_W-1:0]    ones_ff,  ones_in;
   logic [ADDR_W-1:0]   addr_ff,  addr_in;
   logic [MAP_BITS-1:0] shift_ff, shift_in;
   logic                cur_bit;

   assign cur_bit = shift_ff[MAP_BITS-1];

   always_comb begin
      busy_in  = busy_ff;
      found_in = found_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      ones_in  = ones_ff;
      addr_in  = addr_ff;
      shift_in = shift_ff;
      if (start) begin
         busy_in  = 1'b1;
         found_in = 1'b0;
         cnt_in   = '0;
         ones_in  = '0;
         addr_in  = ADDR_W'(POOL_BASE);
         shift_in = map;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         ones_in  = ones_ff + CNT_W'(cur_bit);
         cnt_in   = cnt_ff + PIDX_W'(1);
         if (!found_ff) begin
            if (!cur_bit) begin
               found_in = 1'b1;
               idx_in   = cnt_ff;
            end else begin
               addr_in  = addr_ff + ADDR_W'(PAGE_BYTES);
            end
         end
         if (cnt_ff == PIDX_W'(NUM_PAGES - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      found_ff <= found_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      ones_ff  <= ones_in;
      addr_ff  <= addr_in;
      shift_ff <= shift_in;
   end

   assign scan.busy  = busy_ff;
   assign scan.found = found_ff;
   assign scan.idx   = idx_ff;
   assign scan.ones  = ones_ff;
   assign scan.addr  = addr_ff;

endmodule

// ===== hdl/bitmap_page_allocator_top.sv =====
// bitmap page allocator top level: sequencer, page map and result register
// depends on bpa_pkg, bpa_if, bpa_addr_chk and bpa_scan_unit
//
// usage
//   req_chan carries one request per transfer: opcode allocate or free, and
//   free_addr for a free. rsp_chan returns exactly one result per request:
//   status, the allocated page address (0 unless an allocate succeeds), the
//   occupancy map after the request (bit 63 is page 0) and the free and used
//   page counts.
//   a request is taken only while the sequencer is idle. the scan unit then
//   walks the map one page per cycle, counting used pages and finding the
//   lowest free page; the result is registered when the scan is done and the
//   output register is free, and the sequencer returns to idle with it, so
//   no new request is taken until then. the single bit scan is what sets how
//   often a request can be taken.
//   the result sits in an output register, so the next request is taken
//   while an earlier result still waits; if the receiver stalls, a finished
//   scan holds until that register is free, and the block takes no request.
//   synchronous reset clears the map (every page free), drops rsp valid and
//   returns the sequencer to idle.
module bitmap_page_allocator_top (
   input  logic          clock,
   input  logic          reset,
   bpa_req_if.sink       req_chan,
   bpa_rsp_if.source     rsp_chan
);
   import bpa_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type           state_ff, state_in;
   logic [MAP_BITS-1:0] page_map_ff, page_map_in;

   // request captured at transfer
   opcode_type          op_ff;
   chk_result_type      chk_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [ADDR_W-1:0]   alloc_addr_ff, alloc_addr_in;
   logic [CNT_W-1:0]    used_ff, used_in;

   chk_result_type      chk;
   scan_status_type     scan;
   logic                req_xfer;
   logic                out_free;
   logic                finish;
   logic [MAP_BITS-1:0] alloc_mask;
   logic [MAP_BITS-1:0] free_mask;
   logic                freed_bit;

   bpa_addr_chk u_addr_chk (
      .free_addr (req_chan.free_addr),
      .result    (chk)
   );

   bpa_scan_unit u_scan (
      .clock (clock),
      .reset (reset),
      .start (req_xfer),
      .map   (page_map_ff),
      .scan  (scan)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   // scan done and result register can take the new result
   assign finish         = (state_ff == S_SCAN) && !scan.busy && out_free;

   // map bit 63 is page 0
   assign alloc_mask = MAP_BITS'(1) << (PIDX_W'(MAP_BITS - 1) - scan.idx);
   assign free_mask  = MAP_BITS'(1) << (PIDX_W'(MAP_BITS - 1) - chk_ff.idx);
   assign freed_bit  = |(page_map_ff & free_mask);

   always_comb begin
      state_in      = state_ff;
      page_map_in   = page_map_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      status_in     = status_ff;
      alloc_addr_in = alloc_addr_ff;
      used_in       = used_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (finish) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               alloc_addr_in = '0;
               used_in       = scan.ones;
               if (op_ff == OP_ALLOC) begin
                  if (scan.found) begin
                     status_in     = ST_OK;
                     alloc_addr_in = scan.addr;
                     page_map_in   = page_map_ff | alloc_mask;
                     used_in       = scan.ones + CNT_W'(1);
                  end else begin
                     status_in    = ST_FULL;
                  end
               end else begin
                  status_in = chk_ff.status;
                  if (chk_ff.status == ST_OK) begin
                     // freeing a page that is already free leaves the count alone
                     page_map_in = page_map_ff & ~free_mask;
                     used_in     = scan.ones - CNT_W'(freed_bit);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         page_map_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         page_map_ff  <= page_map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff     <= status_in;
      alloc_addr_ff <= alloc_addr_in;
      used_ff       <= used_in;
      if (req_xfer) begin
         op_ff  <= req_chan.opcode;
         chk_ff <= chk;
      end
   end

   // the map register already holds the post-request map when the result is shown
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.alloc_addr    = alloc_addr_ff;
   assign rsp_chan.occupancy_map = page_map_ff;
   assign rsp_chan.used_pages    = used_ff;
   assign rsp_chan.free_pages    = CNT_W'(NUM_PAGES) - used_ff;

   // page counts always agree with the map carried in the result
   a_count_matches_map: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ($countones(rsp_chan.occupancy_map) == rsp_chan.used_pages))
      else $error("used page count does not match occupancy map");

   // a non-zero page address only comes with a successful allocate
   a_addr_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.alloc_addr != '0)) |-> (rsp_chan.status == ST_OK))
      else $error("page address reported on a failed request");

   // scan unit only runs while the sequencer waits on it
   a_scan_in_scan_state: assert property (@(posedge clock) disable iff (reset)
      scan.busy |-> (state_ff == S_SCAN))
      else $error("scan unit busy outside scan state");

   // a request transfer always starts the scan on the next cycle
   a_xfer_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> scan.busy)
      else $error("request transfer did not start a scan");

endmodule
